FILE: src/fpr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fpr_pkg - shared definitions for the framed packet receiver
// Widths, register map codes, reset values, sequencer states and the
// configuration bundle handed from the register block to the frame engine.
// ---------------------------------------------------------------------------
package fpr_pkg;

   localparam int BYTE_W       = 8;
   localparam int LEN_W        = 6;
   localparam int ERR_W        = 32;
   localparam int MAX_PAYLOAD  = 60;
   localparam int WIN_DEPTH    = MAX_PAYLOAD + 3;
   localparam int WIN_ADDR_W   = $clog2(WIN_DEPTH);
   localparam int QUEUE_PTR_W  = 2;
   localparam int QUEUE_DEPTH  = 1 << QUEUE_PTR_W;
   localparam int CSR_ADDR_W   = 4;
   localparam int CSR_DATA_W   = 32;
   localparam int RSP_DATA_W   = 48;

   localparam logic [BYTE_W-1:0] HEADER_RESET = 8'hA5;
   localparam logic [BYTE_W-1:0] TAIL_RESET   = 8'h5A;
   localparam logic [LEN_W-1:0]  PLEN_RESET   = 6'd8;

   typedef enum logic [1:0] {
      REG_HEADER,
      REG_TAIL,
      REG_PAYLOAD_LEN
   } csr_idx_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_DECIDE,
      ST_E_READ,
      ST_E_LOAD
   } state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] header;
      logic [BYTE_W-1:0] tail;
      logic [LEN_W-1:0]  payload_len;   // already clamped to 1..MAX_PAYLOAD
   } cfg_type;

endpackage
`default_nettype wire

FILE: src/fpr_byte_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fpr_byte_queue - front end byte queue
// Accepts received bytes from the stream side and holds them until the
// frame engine pulls them, so either side can stall on its own.
// ---------------------------------------------------------------------------
module fpr_byte_queue (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      in_valid,
   output      logic                      in_ready,
   input  wire logic [fpr_pkg::BYTE_W-1:0] in_data,
   output      logic                      out_valid,
   input  wire logic                      out_ready,
   output      logic [fpr_pkg::BYTE_W-1:0] out_data
);
   import fpr_pkg::*;

   logic [BYTE_W-1:0]      slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;
   logic                   push, pop;

   assign in_ready  = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   // occupancy must track the pointer distance
   a_count_matches_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH)) |->
         (QUEUE_PTR_W'(count_ff) == QUEUE_PTR_W'(wr_ptr_ff - rd_ptr_ff)))
      else $error("queue occupancy out of step with pointers");

endmodule
`default_nettype wire

FILE: src/fpr_frame_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// fpr_frame_engine - back end window store, frame check and payload output
// Writes each byte into a ring buffer, scans the candidate frame through
// one read port to check header and checksum, compares the newest byte with
// the tail, then replays the payload through a registered output stage.
// ---------------------------------------------------------------------------
module fpr_frame_engine (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire fpr_pkg::cfg_type             cfg,
   input  wire logic                         q_valid,
   output      logic                         q_pop,
   input  wire logic [fpr_pkg::BYTE_W-1:0]   q_data,
   output      logic                         out_valid,
   input  wire logic                         out_ready,
   output      logic [fpr_pkg::BYTE_W-1:0]   out_byte,
   output      logic [fpr_pkg::LEN_W-1:0]    out_pos,
   output      logic                         out_last,
   output      logic [fpr_pkg::ERR_W-1:0]    out_err
);
   import fpr_pkg::*;

   localparam int AW1 = WIN_ADDR_W + 1;

   function automatic logic [WIN_ADDR_W-1:0] next_addr(input logic [WIN_ADDR_W-1:0] a);
      logic [WIN_ADDR_W-1:0] r;
      if (a == WIN_ADDR_W'(WIN_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = a + 1'b1;
      end
      return r;
   endfunction

   logic [BYTE_W-1:0]     win_mem [WIN_DEPTH];
   logic [BYTE_W-1:0]     rdata_ff;

   state_type             state_ff, state_in;
   logic [WIN_ADDR_W-1:0] wr_ptr_ff, rd_addr_ff, base_ff;
   logic [LEN_W-1:0]      count_ff, idx_ff, didx_ff;
   logic [BYTE_W-1:0]     newest_ff, sum_ff, cks_ff;
   logic                  hdr_ok_ff, dv_ff;
   logic [ERR_W-1:0]      rejects_ff;
   logic                  out_valid_ff, out_last_ff;
   logic [BYTE_W-1:0]     out_byte_ff;
   logic [LEN_W-1:0]      out_pos_ff;
   logic [ERR_W-1:0]      out_err_ff;

   logic [LEN_W-1:0]      frame_len, count_inc;
   logic [AW1-1:0]        start_sum;
   logic [WIN_ADDR_W-1:0] start_addr;
   logic                  rd_en, scan_last, emit_last, out_free, out_load, frame_ok;
   logic                  check_due;

   assign frame_len = cfg.payload_len + LEN_W'(3);
   assign count_inc = (count_ff < frame_len) ? count_ff + 1'b1 : count_ff;
   assign check_due = (count_inc >= frame_len);
   assign start_sum = AW1'(wr_ptr_ff) + AW1'(WIN_DEPTH) - AW1'(cfg.payload_len) - AW1'(2);
   assign start_addr = (start_sum >= AW1'(WIN_DEPTH)) ?
                       WIN_ADDR_W'(start_sum - AW1'(WIN_DEPTH)) : WIN_ADDR_W'(start_sum);
   assign scan_last = (idx_ff == cfg.payload_len + LEN_W'(1));
   assign emit_last = (idx_ff == cfg.payload_len - LEN_W'(1));
   assign out_free  = !out_valid_ff || out_ready;
   assign frame_ok  = hdr_ok_ff && (newest_ff == cfg.tail) && (cks_ff == sum_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && check_due) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: state_in = ST_DECIDE;
         ST_DECIDE: begin
            state_in = frame_ok ? ST_E_READ : ST_IDLE;
         end
         ST_E_READ: state_in = ST_E_LOAD;
         ST_E_LOAD: begin
            if (out_free) begin
               state_in = emit_last ? ST_IDLE : ST_E_READ;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      q_pop    = 1'b0;
      rd_en    = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         ST_IDLE:   q_pop    = q_valid;
         ST_SCAN:   rd_en    = 1'b1;
         ST_E_READ: rd_en    = 1'b1;
         ST_E_LOAD: out_load = out_free;
         default: begin
            q_pop    = 1'b0;
            rd_en    = 1'b0;
            out_load = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         win_mem[wr_ptr_ff] <= q_data;
      end
      if (rd_en) begin
         rdata_ff <= win_mem[rd_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wr_ptr_ff    <= '0;
         count_ff     <= '0;
         rejects_ff   <= '0;
         dv_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         dv_ff    <= (state_ff == ST_SCAN);
         if (q_pop) begin
            wr_ptr_ff <= next_addr(wr_ptr_ff);
            count_ff  <= count_inc;
         end
         if (state_ff == ST_DECIDE) begin
            if (frame_ok) begin
               count_ff <= '0;
            end else begin
               rejects_ff <= rejects_ff + 1'b1;
               count_ff   <= frame_len;
            end
         end
         if (out_load) begin
            out_valid_ff <= 1'b1;
         end else if (out_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (q_pop) begin
         newest_ff  <= q_data;
         rd_addr_ff <= start_addr;
         base_ff    <= start_addr;
         idx_ff     <= '0;
         sum_ff     <= '0;
      end
      if (rd_en) begin
         rd_addr_ff <= next_addr(rd_addr_ff);
      end
      if (state_ff == ST_SCAN) begin
         idx_ff <= idx_ff + 1'b1;
      end
      didx_ff <= idx_ff;
      if (dv_ff) begin
         if (didx_ff == '0) begin
            hdr_ok_ff <= (rdata_ff == cfg.header);
         end else if (didx_ff == cfg.payload_len + LEN_W'(1)) begin
            cks_ff <= rdata_ff;
         end else begin
            sum_ff <= sum_ff + rdata_ff;
         end
      end
      if (state_ff == ST_DECIDE) begin
         rd_addr_ff <= next_addr(base_ff);
         idx_ff     <= '0;
      end
      if (out_load) begin
         out_byte_ff <= rdata_ff;
         out_pos_ff  <= idx_ff;
         out_last_ff <= emit_last;
         out_err_ff  <= rejects_ff;
         idx_ff      <= idx_ff + 1'b1;
      end
   end

   assign out_valid = out_valid_ff;
   assign out_byte  = out_byte_ff;
   assign out_pos   = out_pos_ff;
   assign out_last  = out_last_ff;
   assign out_err   = out_err_ff;

   // the fill count may sit above a shortened frame, so only the pointer is bounded
   a_ptrs_in_range: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff < WIN_ADDR_W'(WIN_DEPTH)))
      else $error("window pointer out of range");

   a_rejects_from_decide: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$stable(rejects_ff) |-> $past(state_ff) == ST_DECIDE)
      else $error("reject count moved outside a frame decision");

   a_scan_only_when_full: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && state_ff == ST_SCAN && $past(state_ff) == ST_IDLE
         |-> count_ff >= frame_len)
      else $error("frame scan started before the window was full");

   a_no_pop_while_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_E_LOAD || state_ff == ST_E_READ) |=> !dv_ff)
      else $error("scan data seen during payload replay");

endmodule
`default_nettype wire

FILE: src/framed_packet_receiver.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// framed_packet_receiver - header/tail/checksum packet deframer
// Slides over a received byte stream, recognises framed packets and
// streams out their payload bytes.
// ---------------------------------------------------------------------------
// A byte beat on req_ lands in a four-entry queue and is then written into a
// 63-entry window RAM. Once payload_length+3 bytes have arrived since reset
// or the last good packet, every further byte triggers a check of the newest
// frame: oldest byte equal to the header, newest equal to the tail, and the
// byte before the tail equal to the 8-bit sum of the payload. A byte that
// triggers no check is taken in a single engine state; a check reads the
// frame one byte a cycle through the single RAM read port, and a good
// packet is then replayed with a read and a load state per payload byte
// (waiting while rsp_ stalls). Each payload byte leaves on rsp_ with its
// position, tlast on the final one, and the wrapping count of rejected
// window positions so far. A payload_length of zero behaves as 1 and values
// above 60 as 60. Write the registers only while the block is idle.
// ---------------------------------------------------------------------------
module framed_packet_receiver (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // input stream, tdata: rx_byte[7:0]
   input  wire logic                               req_tvalid,
   output      logic                               req_tready,
   input  wire logic [fpr_pkg::BYTE_W-1:0]         req_tdata,
   // result stream, tdata: payload_byte[7:0], byte_position[13:8],
   // error_count[45:14], zero fill [47:46]; tlast: last_byte
   output      logic                               rsp_tvalid,
   input  wire logic                               rsp_tready,
   output      logic [fpr_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output      logic                               rsp_tlast,
   // register port
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [fpr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [fpr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output      logic [fpr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output      logic                               csr_pready
);
   import fpr_pkg::*;

   logic [BYTE_W-1:0] header_ff, header_in;
   logic [BYTE_W-1:0] tail_ff, tail_in;
   logic [LEN_W-1:0]  plen_ff, plen_in;
   logic [LEN_W-1:0]  plen_eff;
   csr_idx_type       csr_idx;
   logic              csr_wr;
   cfg_type           cfg;

   logic              q_valid, q_pop;
   logic [BYTE_W-1:0] q_data;
   logic [BYTE_W-1:0] out_byte;
   logic [LEN_W-1:0]  out_pos;
   logic [ERR_W-1:0]  out_err;

   // register access: always ready, write on the access phase
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_idx_type'(csr_paddr[CSR_ADDR_W-1:2]);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      header_in = header_ff;
      tail_in   = tail_ff;
      plen_in   = plen_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_HEADER:      header_in = csr_pwdata[BYTE_W-1:0];
            REG_TAIL:        tail_in   = csr_pwdata[BYTE_W-1:0];
            REG_PAYLOAD_LEN: plen_in   = csr_pwdata[LEN_W-1:0];
            default: begin
               header_in = header_ff;
               tail_in   = tail_ff;
               plen_in   = plen_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff <= HEADER_RESET;
         tail_ff   <= TAIL_RESET;
         plen_ff   <= PLEN_RESET;
      end else begin
         header_ff <= header_in;
         tail_ff   <= tail_in;
         plen_ff   <= plen_in;
      end
   end

   always_comb begin
      case (csr_idx)
         REG_HEADER:      csr_prdata = CSR_DATA_W'(header_ff);
         REG_TAIL:        csr_prdata = CSR_DATA_W'(tail_ff);
         REG_PAYLOAD_LEN: csr_prdata = CSR_DATA_W'(plen_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // clamp the length so the frame always fits the window
   always_comb begin
      plen_eff = plen_ff;
      if (plen_ff == '0) begin
         plen_eff = LEN_W'(1);
      end else if (plen_ff > LEN_W'(MAX_PAYLOAD)) begin
         plen_eff = LEN_W'(MAX_PAYLOAD);
      end
   end

   assign cfg.header      = header_ff;
   assign cfg.tail        = tail_ff;
   assign cfg.payload_len = plen_eff;

   // front end: hold incoming beats
   fpr_byte_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .out_valid (q_valid),
      .out_ready (q_pop),
      .out_data  (q_data)
   );

   // back end: window, check and payload replay
   fpr_frame_engine u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_data    (q_data),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_byte  (out_byte),
      .out_pos   (out_pos),
      .out_last  (rsp_tlast),
      .out_err   (out_err)
   );

   assign rsp_tdata = {2'b00, out_err, out_pos, out_byte};

endmodule
`default_nettype wire
